// ----- src/pdm_pkg.sv -----
// Package for the paired-read duplicate marker.
// Record and decision types shared by the stage modules and the top level.
package pdm_pkg;

   localparam int LibWidth    = 8;
   localparam int RefWidth    = 8;
   localparam int OrientWidth = 8;
   localparam int PosWidth    = 31;
   localparam int ScoreWidth  = 16;
   localparam int NameWidth   = 63;

   // one read-pair end record as held in the input register
   typedef struct packed {
      logic                          region_start;
      logic [LibWidth-1:0]           library_id;
      logic [RefWidth-1:0]           first_ref_id;
      logic [RefWidth-1:0]           second_ref_id;
      logic [OrientWidth-1:0]        pair_orientation;
      logic [PosWidth-1:0]           first_position;
      logic [PosWidth-1:0]           second_position;
      logic signed [ScoreWidth-1:0]  quality_score;
      logic [NameWidth-1:0]          read_name_id;
   } record_type;

   // outcome of one record against the open group
   typedef struct packed {
      logic                 emit;
      logic [NameWidth-1:0] name;
   } decision_type;

endpackage

// ----- src/pdm_in_stage.sv -----
// Input register of the duplicate marker: holds one record word.
// Depends on pdm_pkg for the record type.
module pdm_in_stage
   import pdm_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   output logic       in_ready,
   input  record_type in_rec,
   input  logic       advance,
   output logic       stage_valid,
   output record_type stage_rec
);

   logic       valid_ff, valid_in;
   record_type rec_ff;

   // take a word when empty or when the held word moves on this cycle
   assign in_ready = !valid_ff || advance;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         rec_ff <= in_rec;
      end
   end

   assign stage_valid = valid_ff;
   assign stage_rec   = rec_ff;

endmodule

// ----- src/pdm_group_ctrl.sv -----
// Group tracker: stored key and best record, key compare and score compare.
// Depends on pdm_pkg for record and decision types.
module pdm_group_ctrl
   import pdm_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         advance,
   input  record_type   rec,
   output decision_type decision
);

   logic                         open_ff;
   logic [LibWidth-1:0]          key_library_ff;
   logic [RefWidth-1:0]          key_first_ref_ff;
   logic [RefWidth-1:0]          key_second_ref_ff;
   logic [OrientWidth-1:0]       key_orientation_ff;
   logic [PosWidth-1:0]          key_first_pos_ff;
   logic [PosWidth-1:0]          key_second_pos_ff;
   logic signed [ScoreWidth-1:0] best_score_ff;
   logic [NameWidth-1:0]         best_name_ff;

   logic same_group;
   logic better;
   logic take_best;

   // same group: open, no region start, all key fields equal
   assign same_group = open_ff && !rec.region_start
                       && (key_library_ff     == rec.library_id)
                       && (key_first_ref_ff   == rec.first_ref_id)
                       && (key_second_ref_ff  == rec.second_ref_id)
                       && (key_orientation_ff == rec.pair_orientation)
                       && (key_first_pos_ff   == rec.first_position)
                       && (key_second_pos_ff  == rec.second_position);

   // ties keep the earlier best
   assign better    = rec.quality_score > best_score_ff;
   assign take_best = !same_group || better;

   always_comb begin
      decision.emit = same_group;
      decision.name = better ? best_name_ff : rec.read_name_id;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff <= 1'b0;
      end else if (advance) begin
         open_ff <= 1'b1;
      end
   end

   // key and best update; key rewrite on a better score is harmless
   always_ff @(posedge clock) begin
      if (advance && take_best) begin
         key_library_ff     <= rec.library_id;
         key_first_ref_ff   <= rec.first_ref_id;
         key_second_ref_ff  <= rec.second_ref_id;
         key_orientation_ff <= rec.pair_orientation;
         key_first_pos_ff   <= rec.first_position;
         key_second_pos_ff  <= rec.second_position;
         best_score_ff      <= rec.quality_score;
         best_name_ff       <= rec.read_name_id;
      end
   end

endmodule

// ----- src/pdm_out_stage.sv -----
// Result register of the duplicate marker: holds one duplicate name word.
// Depends on pdm_pkg for the decision type.
module pdm_out_stage
   import pdm_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  decision_type         decision,
   output logic                 out_free,
   output logic                 out_valid,
   input  logic                 out_ready,
   output logic [NameWidth-1:0] out_name
);

   logic                 valid_ff, valid_in;
   logic [NameWidth-1:0] name_ff;

   // free when empty or when the held word is taken this cycle
   assign out_free = !valid_ff || out_ready;
   assign valid_in = advance ? decision.emit : (out_free ? 1'b0 : valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && decision.emit) begin
         name_ff <= decision.name;
      end
   end

   assign out_valid = valid_ff;
   assign out_name  = name_ff;

endmodule

// ----- src/paired_read_duplicate_marker_unit.sv -----
// Top level of the paired-read duplicate marker.
// Depends on pdm_pkg, pdm_in_stage, pdm_group_ctrl and pdm_out_stage.
//
//   channel   prefix  direction  word
//   input     req_    in         one sorted read-pair end record
//   result    rsp_    out        name id of one duplicate record
//
// One record per cycle while the result side does not stall: a record is held
// in the input register, where the key and score compares decide it, and the
// duplicate name it yields (if any) moves on into the result register, which
// drives rsp_valid. A full result register that is not taken stalls the input
// register, which then holds req_ready low. Reset clears the valid bits and
// the open-group flag; the first record after reset always opens a group.
module paired_read_duplicate_marker_unit
   import pdm_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic                         req_region_start,
   input  logic [LibWidth-1:0]          req_library_id,
   input  logic [RefWidth-1:0]          req_first_ref_id,
   input  logic [RefWidth-1:0]          req_second_ref_id,
   input  logic [OrientWidth-1:0]       req_pair_orientation,
   input  logic [PosWidth-1:0]          req_first_position,
   input  logic [PosWidth-1:0]          req_second_position,
   input  logic signed [ScoreWidth-1:0] req_quality_score,
   input  logic [NameWidth-1:0]         req_read_name_id,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [NameWidth-1:0]         rsp_duplicate_name_id
);

   record_type   req_rec;
   record_type   stage_rec;
   decision_type decision;
   logic         stage_valid;
   logic         out_free;
   logic         advance;

   always_comb begin
      req_rec.region_start     = req_region_start;
      req_rec.library_id       = req_library_id;
      req_rec.first_ref_id     = req_first_ref_id;
      req_rec.second_ref_id    = req_second_ref_id;
      req_rec.pair_orientation = req_pair_orientation;
      req_rec.first_position   = req_first_position;
      req_rec.second_position  = req_second_position;
      req_rec.quality_score    = req_quality_score;
      req_rec.read_name_id     = req_read_name_id;
   end

   // held record moves on when the result register has room
   assign advance = stage_valid && out_free;

   pdm_in_stage u_in_stage (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_valid),
      .in_ready    (req_ready),
      .in_rec      (req_rec),
      .advance     (advance),
      .stage_valid (stage_valid),
      .stage_rec   (stage_rec)
   );

   pdm_group_ctrl u_group_ctrl (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .rec      (stage_rec),
      .decision (decision)
   );

   pdm_out_stage u_out_stage (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .decision  (decision),
      .out_free  (out_free),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_name  (rsp_duplicate_name_id)
   );

   // a region start opens a group and never yields a duplicate
   assert property (@(posedge clock) disable iff (reset)
      advance && stage_rec.region_start |=> !rsp_valid)
      else $error("region start produced a duplicate word");

   // a record held in the input register is not lost while stalled
   assert property (@(posedge clock) disable iff (reset)
      stage_valid && !advance |=> stage_valid && $stable(stage_rec))
      else $error("stalled record dropped or changed");

   // reset leaves both registers empty
   assert property (@(posedge clock)
      reset |=> !rsp_valid && !stage_valid)
      else $error("valid bit set right after reset");

   // a new result word appears only from a record that moved on
   assert property (@(posedge clock) disable iff (reset)
      !advance && out_free |=> !rsp_valid)
      else $error("result word without a record");

endmodule
